[design/pst_pkg.sv]
package pst_pkg;

    // table size and coordinate width
    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 16;

    // the input coordinates are 16 bits wide, so at most 16 bits take part in a compare
    localparam int CMP_BITS  = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int WORD_BITS = 2 * CMP_BITS;
    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // one classified command from the front to the back
    typedef struct packed {
        op_t                 op;
        logic [CMP_BITS-1:0] px;
        logic [CMP_BITS-1:0] py;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD,
        BK_CLEAR,
        BK_SCAN,
        BK_MOVE_RD,
        BK_MOVE_WR,
        BK_FINISH
    } back_state_t;

endpackage

[design/pst_ram.sv]
module pst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/pst_front.sv]
module pst_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic signed [15:0]   s_point_x,
    input  logic signed [15:0]   s_point_y,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output pst_pkg::cmd_t        cmd
);

    pst_pkg::cmd_t cmd_in;
    pst_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    logic          pop;

    // classify the word and keep only the compared coordinate bits
    always_comb begin
        cmd_in.op = pst_pkg::op_t'(s_kind);
        cmd_in.px = s_point_x[pst_pkg::CMP_BITS-1:0];
        cmd_in.py = s_point_y[pst_pkg::CMP_BITS-1:0];
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[design/pst_back.sv]
module pst_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  pst_pkg::cmd_t                 cmd,
    output logic                          ram_we,
    output logic [pst_pkg::IDX_BITS-1:0]  ram_waddr,
    output logic [pst_pkg::WORD_BITS-1:0] ram_wdata,
    output logic [pst_pkg::IDX_BITS-1:0]  ram_raddr,
    input  logic [pst_pkg::WORD_BITS-1:0] ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [5:0]                    m_slot_index,
    output logic [6:0]                    m_entry_count,
    output logic                          m_is_full,
    output logic                          m_is_empty
);

    localparam logic [pst_pkg::CNT_BITS-1:0] CNT_FULL = pst_pkg::CNT_BITS'(pst_pkg::CAPACITY);
    localparam logic [pst_pkg::CNT_BITS-1:0] CNT_ONE  = pst_pkg::CNT_BITS'(1);

    pst_pkg::back_state_t              state_reg;
    pst_pkg::back_state_t              state_next;
    pst_pkg::op_t                      op_reg;
    logic [pst_pkg::WORD_BITS-1:0]     target_reg;
    logic [pst_pkg::CNT_BITS-1:0]      count_reg;
    logic [pst_pkg::CNT_BITS-1:0]      scan_reg;
    logic [pst_pkg::IDX_BITS-1:0]      cmp_idx_reg;
    logic                              pend_reg;
    pst_pkg::status_t                  res_status_reg;
    logic [pst_pkg::IDX_BITS-1:0]      res_slot_reg;
    logic [pst_pkg::CNT_BITS-1:0]      last_cnt;
    logic [31:0]                       slot_wide;
    logic [31:0]                       count_wide;
    logic                              hit;
    logic                              scan_end;
    logic                              issue;
    logic                              out_free;

    logic                              m_valid_reg;
    logic [1:0]                        m_status_reg;
    logic [5:0]                        m_slot_reg;
    logic [6:0]                        m_count_reg;
    logic                              m_full_reg;
    logic                              m_empty_reg;

    assign last_cnt = count_reg - CNT_ONE;
    assign hit      = pend_reg && (ram_rdata == target_reg);
    assign scan_end = (scan_reg == count_reg);
    assign issue    = !hit && !scan_end;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pst_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.op)
                        pst_pkg::OP_ADD:    state_next = pst_pkg::BK_ADD;
                        pst_pkg::OP_CLEAR:  state_next = pst_pkg::BK_CLEAR;
                        default:            state_next = pst_pkg::BK_SCAN;
                    endcase
                end
            end
            pst_pkg::BK_ADD:   state_next = pst_pkg::BK_FINISH;
            pst_pkg::BK_CLEAR: state_next = pst_pkg::BK_FINISH;
            pst_pkg::BK_SCAN: begin
                if (hit) begin
                    state_next = (op_reg == pst_pkg::OP_REMOVE) ? pst_pkg::BK_MOVE_RD
                                                               : pst_pkg::BK_FINISH;
                end else if (scan_end) begin
                    state_next = pst_pkg::BK_FINISH;
                end
            end
            pst_pkg::BK_MOVE_RD: state_next = pst_pkg::BK_MOVE_WR;
            pst_pkg::BK_MOVE_WR: state_next = pst_pkg::BK_FINISH;
            pst_pkg::BK_FINISH: begin
                if (out_free) begin
                    state_next = pst_pkg::BK_IDLE;
                end
            end
            default: state_next = pst_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = count_reg[pst_pkg::IDX_BITS-1:0];
        ram_wdata = target_reg;
        ram_raddr = scan_reg[pst_pkg::IDX_BITS-1:0];
        case (state_reg)
            pst_pkg::BK_IDLE: cmd_ready = 1'b1;
            pst_pkg::BK_ADD:  ram_we = (count_reg != CNT_FULL);
            pst_pkg::BK_MOVE_RD: ram_raddr = last_cnt[pst_pkg::IDX_BITS-1:0];
            pst_pkg::BK_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = res_slot_reg;
                ram_wdata = ram_rdata;
            end
            default: cmd_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pst_pkg::BK_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == pst_pkg::BK_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                pst_pkg::BK_IDLE: pend_reg <= 1'b0;
                pst_pkg::BK_ADD: begin
                    if (count_reg != CNT_FULL) begin
                        count_reg <= count_reg + CNT_ONE;
                    end
                end
                pst_pkg::BK_CLEAR: count_reg <= '0;
                pst_pkg::BK_SCAN:  pend_reg <= issue;
                pst_pkg::BK_MOVE_WR: count_reg <= last_cnt;
                default: pend_reg <= 1'b0;
            endcase
        end
    end

    // payload and scan datapath, no reset needed
    always_ff @(posedge aclk) begin
        case (state_reg)
            pst_pkg::BK_IDLE: begin
                op_reg     <= cmd.op;
                target_reg <= {cmd.py, cmd.px};
                scan_reg   <= '0;
            end
            pst_pkg::BK_ADD: begin
                if (count_reg == CNT_FULL) begin
                    res_status_reg <= pst_pkg::ST_FULL;
                    res_slot_reg   <= '0;
                end else begin
                    res_status_reg <= pst_pkg::ST_OK;
                    res_slot_reg   <= count_reg[pst_pkg::IDX_BITS-1:0];
                end
            end
            pst_pkg::BK_CLEAR: begin
                res_status_reg <= pst_pkg::ST_OK;
                res_slot_reg   <= '0;
            end
            pst_pkg::BK_SCAN: begin
                cmp_idx_reg <= scan_reg[pst_pkg::IDX_BITS-1:0];
                if (issue) begin
                    scan_reg <= scan_reg + CNT_ONE;
                end
                if (hit) begin
                    res_status_reg <= pst_pkg::ST_OK;
                    res_slot_reg   <= cmp_idx_reg;
                end else if (scan_end) begin
                    res_status_reg <= pst_pkg::ST_ABSENT;
                    res_slot_reg   <= '0;
                end
            end
            pst_pkg::BK_FINISH: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_slot_reg   <= slot_wide[5:0];
                    m_count_reg  <= count_wide[6:0];
                    m_full_reg   <= (count_reg == CNT_FULL);
                    m_empty_reg  <= (count_reg == '0);
                end
            end
            default: ;
        endcase
    end

    assign slot_wide  = 32'(res_slot_reg);
    assign count_wide = 32'(count_reg);

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot_index  = m_slot_reg;
    assign m_entry_count = m_count_reg;
    assign m_is_full     = m_full_reg;
    assign m_is_empty    = m_empty_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pst_pkg::BK_ADD && count_reg != CNT_FULL)
        |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("add did not grow the table by one");

    a_full_only_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pst_pkg::BK_FINISH && res_status_reg == pst_pkg::ST_FULL)
        |-> op_reg == pst_pkg::OP_ADD)
        else $error("full status on an operation other than add");

    a_find_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pst_pkg::BK_FINISH && op_reg == pst_pkg::OP_FIND
         && res_status_reg == pst_pkg::ST_OK)
        |-> {1'b0, res_slot_reg} < {1'b0, count_reg})
        else $error("found slot beyond the entry count");
`endif

endmodule

[design/point_set_table_unit.sv]
// Unordered table of up to CAPACITY signed points with swap-on-remove. Each input word
// carries one operation (add, find, remove, clear) and yields exactly one result word
// with status, slot, entry count and full/empty flags. Add and clear execute without a
// scan; find walks the point memory one entry per cycle through its single read port,
// and remove does the same scan, then moves the last entry into the freed slot. A
// two-word command queue sits between the input side and the execution side, and the
// result sits in an output register, so the input keeps taking words while a result
// waits, until the queue is full. Stored points are not zeroed at reset or on clear;
// only entries below the count are ever read.
module point_set_table_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [5:0]         m_slot_index,
    output logic [6:0]         m_entry_count,
    output logic               m_is_full,
    output logic               m_is_empty
);

    // front to back command path
    logic          cmd_valid;
    logic          cmd_ready;
    pst_pkg::cmd_t cmd;

    // point memory port
    logic                          ram_we;
    logic [pst_pkg::IDX_BITS-1:0]  ram_waddr;
    logic [pst_pkg::WORD_BITS-1:0] ram_wdata;
    logic [pst_pkg::IDX_BITS-1:0]  ram_raddr;
    logic [pst_pkg::WORD_BITS-1:0] ram_rdata;

    // accept and classify each word, queue it for execution
    pst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // execute: append, scan, swap-remove, clear; hold the result until taken
    pst_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_index  (m_slot_index),
        .m_entry_count (m_entry_count),
        .m_is_full     (m_is_full),
        .m_is_empty    (m_is_empty)
    );

    // point storage, {y, x} per slot
    pst_ram #(
        .WIDTH (pst_pkg::WORD_BITS),
        .DEPTH (pst_pkg::CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
